@@ sv/anx_pkg.sv @@
// Package for the Annex B NAL splitter: buffer limits, field widths,
// byte codes and the descriptor type. No dependencies.
`default_nettype none

package anx_pkg;

  // Largest buffer tracked; the position counter saturates here
  localparam int MAX_BUFFER_BYTES = 1048576;

  localparam int POS_W    = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int IDX_W    = $clog2(MAX_BUFFER_BYTES);
  localparam int OFFSET_W = IDX_W;
  localparam int LENGTH_W = POS_W;
  localparam int PATCH_W  = 19;
  localparam int BYTE_W   = 8;
  localparam int AVC_W    = 5;
  localparam int HEVC_W   = 6;
  localparam int ZRUN_W   = 2;

  localparam logic [POS_W-1:0]   POS_MAX     = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(MAX_BUFFER_BYTES - 1);
  localparam logic [PATCH_W-1:0] PATCH_LIMIT = {PATCH_W{1'b1}};

  // Byte codes
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE     = 8'h01;
  localparam logic [BYTE_W-1:0] HEVC_TRAIL_R = 8'h02;
  localparam logic [BYTE_W-1:0] LAYER_MASK   = 8'hF8;

  // Zero-run and header-count saturation point
  localparam logic [ZRUN_W-1:0] RUN_SAT = 2'd2;

  typedef struct packed {
    logic                nal_valid;
    logic [OFFSET_W-1:0] nal_offset;
    logic [LENGTH_W-1:0] nal_length;
    logic [AVC_W-1:0]    avc_type;
    logic [HEVC_W-1:0]   hevc_type;
    logic                rewrite_to_trail_n;
    logic [PATCH_W-1:0]  patch_count;
    logic                end_of_buffer;
  } desc_t;

endpackage

`default_nettype wire

@@ sv/anx_if.sv @@
// Channel interfaces for the Annex B NAL splitter: byte input and
// descriptor output, valid/ready. Depends on anx_pkg.
`default_nettype none

interface anx_in_if;
  import anx_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface anx_out_if;
  import anx_pkg::*;
  logic                valid;
  logic                ready;
  logic                nal_valid;
  logic [OFFSET_W-1:0] nal_offset;
  logic [LENGTH_W-1:0] nal_length;
  logic [AVC_W-1:0]    avc_type;
  logic [HEVC_W-1:0]   hevc_type;
  logic                rewrite_to_trail_n;
  logic [PATCH_W-1:0]  patch_count;
  logic                end_of_buffer;

  modport source (
    output valid, output nal_valid, output nal_offset, output nal_length,
    output avc_type, output hevc_type, output rewrite_to_trail_n,
    output patch_count, output end_of_buffer, input ready
  );
  modport sink (
    input valid, input nal_valid, input nal_offset, input nal_length,
    input avc_type, input hevc_type, input rewrite_to_trail_n,
    input patch_count, input end_of_buffer, output ready
  );
endinterface

`default_nettype wire

@@ sv/anx_scan.sv @@
// Byte scanner: start-code detection, payload tracking and descriptor
// build for one accepted beat. Depends on anx_pkg.
`default_nettype none

module anx_scan (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       beat_fire,
  input  wire logic [anx_pkg::BYTE_W-1:0] beat_byte,
  input  wire logic                       beat_last,
  output logic                            desc_valid,
  output anx_pkg::desc_t                  desc
);
  import anx_pkg::*;

  logic [POS_W-1:0]   pos_r,        pos_nxt;
  logic               in_payload_r, in_payload_nxt;
  logic [ZRUN_W-1:0]  zrun_r,       zrun_nxt;
  logic [IDX_W-1:0]   start_r,      start_nxt;
  logic [POS_W-1:0]   nz_end_r,     nz_end_nxt;
  logic [BYTE_W-1:0]  head0_r,      head0_nxt;
  logic [BYTE_W-1:0]  head1_r,      head1_nxt;
  logic [ZRUN_W-1:0]  hcount_r,     hcount_nxt;
  logic [PATCH_W-1:0] total_r,      total_nxt;

  logic [IDX_W-1:0]    idx;
  logic [POS_W-1:0]    idx_p1;
  logic [IDX_W-1:0]    delim_start;
  logic                is_delim;
  logic [ZRUN_W-1:0]   zrun_upd;
  logic [POS_W-1:0]   nz_upd;
  logic [BYTE_W-1:0]   head0_upd, head1_upd;
  logic [ZRUN_W-1:0]   hcount_upd;
  logic [POS_W-1:0]    d_nz;
  logic [BYTE_W-1:0]   d_b0, d_b1;
  logic [POS_W-1:0]    start_ext;
  logic                has_len;
  logic [LENGTH_W-1:0] len;
  logic                flag;
  logic [PATCH_W-1:0]  total_upd;

  // Byte index, clamped once the counter has saturated
  assign idx         = (pos_r == POS_MAX) ? IDX_LAST : pos_r[IDX_W-1:0];
  assign idx_p1      = POS_W'(idx) + POS_W'(1);
  assign delim_start = (idx == IDX_LAST) ? IDX_LAST : idx + IDX_W'(1);
  assign is_delim    = (beat_byte == BYTE_ONE) && (zrun_r == RUN_SAT);

  // Ordinary byte: zero run, header capture, last non-zero end
  always_comb begin
    zrun_upd   = zrun_r;
    nz_upd     = nz_end_r;
    head0_upd  = head0_r;
    head1_upd  = head1_r;
    hcount_upd = hcount_r;
    if (beat_byte == BYTE_ZERO) begin
      if (zrun_r != RUN_SAT) zrun_upd = zrun_r + ZRUN_W'(1);
    end else begin
      zrun_upd = '0;
    end
    if (in_payload_r) begin
      if (hcount_r != RUN_SAT) begin
        if (hcount_r[0]) head1_upd = beat_byte;
        else             head0_upd = beat_byte;
        hcount_upd = hcount_r + ZRUN_W'(1);
      end
      if (beat_byte != BYTE_ZERO) nz_upd = idx_p1;
    end
  end

  // Descriptor of the payload being closed
  assign d_nz      = is_delim ? nz_end_r : nz_upd;
  assign d_b0      = is_delim ? head0_r  : head0_upd;
  assign d_b1      = is_delim ? head1_r  : head1_upd;
  assign start_ext = POS_W'(start_r);
  assign has_len   = in_payload_r && (d_nz > start_ext);
  assign len       = has_len ? LENGTH_W'(d_nz - start_ext) : '0;
  assign flag      = has_len && (len > LENGTH_W'(1)) && (d_b0 == HEVC_TRAIL_R)
                     && ((d_b1 & LAYER_MASK) == BYTE_ZERO);
  assign total_upd = (flag && (total_r != PATCH_LIMIT)) ? total_r + PATCH_W'(1)
                                                        : total_r;

  assign desc_valid = beat_fire && ((is_delim && has_len) || beat_last);

  always_comb begin
    desc.nal_valid          = has_len;
    desc.nal_offset         = has_len ? start_r : '0;
    desc.nal_length         = len;
    desc.avc_type           = has_len ? d_b0[AVC_W-1:0] : '0;
    desc.hevc_type          = has_len ? d_b0[HEVC_W:1] : '0;
    desc.rewrite_to_trail_n = flag;
    desc.patch_count        = total_upd;
    desc.end_of_buffer      = beat_last;
  end

  // Next state for an accepted beat
  always_comb begin
    pos_nxt        = pos_r;
    in_payload_nxt = in_payload_r;
    zrun_nxt       = zrun_r;
    start_nxt      = start_r;
    nz_end_nxt     = nz_end_r;
    head0_nxt      = head0_r;
    head1_nxt      = head1_r;
    hcount_nxt     = hcount_r;
    total_nxt      = total_r;
    if (beat_fire) begin
      if (beat_last) begin
        pos_nxt        = '0;
        in_payload_nxt = 1'b0;
        zrun_nxt       = '0;
        start_nxt      = '0;
        nz_end_nxt     = '0;
        head0_nxt      = '0;
        head1_nxt      = '0;
        hcount_nxt     = '0;
        total_nxt      = '0;
      end else begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
        if (is_delim) begin
          // count only moves when a payload is actually closed
          total_nxt      = total_upd;
          in_payload_nxt = 1'b1;
          start_nxt      = delim_start;
          nz_end_nxt     = POS_W'(delim_start);
          head0_nxt      = '0;
          head1_nxt      = '0;
          hcount_nxt     = '0;
          zrun_nxt       = '0;
        end else begin
          zrun_nxt   = zrun_upd;
          nz_end_nxt = nz_upd;
          head0_nxt  = head0_upd;
          head1_nxt  = head1_upd;
          hcount_nxt = hcount_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_payload_r <= 1'b0;
      zrun_r       <= '0;
      start_r      <= '0;
      nz_end_r     <= '0;
      head0_r      <= '0;
      head1_r      <= '0;
      hcount_r     <= '0;
      total_r      <= '0;
    end else begin
      pos_r        <= pos_nxt;
      in_payload_r <= in_payload_nxt;
      zrun_r       <= zrun_nxt;
      start_r      <= start_nxt;
      nz_end_r     <= nz_end_nxt;
      head0_r      <= head0_nxt;
      head1_r      <= head1_nxt;
      hcount_r     <= hcount_nxt;
      total_r      <= total_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/anx_skid.sv @@
// Descriptor output register with a skid stage, so the upstream ready is
// a plain register. Depends on anx_pkg.
`default_nettype none

module anx_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  input  wire anx_pkg::desc_t  up_data,
  output logic                 up_ready,
  output logic                 down_valid,
  output anx_pkg::desc_t       down_data,
  input  wire logic            down_ready
);
  import anx_pkg::*;

  logic  main_v_r, main_v_nxt;
  logic  skid_v_r, skid_v_nxt;
  desc_t main_d_r, main_d_nxt;
  desc_t skid_d_r, skid_d_nxt;
  logic  push, pop;

  assign up_ready   = !skid_v_r;
  assign down_valid = main_v_r;
  assign down_data  = main_d_r;
  assign push       = up_valid && up_ready;
  assign pop        = main_v_r && down_ready;

  // Main register refills from the skid first, then from upstream
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_d_nxt = up_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = up_data;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

@@ sv/annexb_nal_splitter.sv @@
// Annex B NAL unit splitter, top level.
//
// in_chan takes one buffer byte per beat, with last_byte on the final byte.
// Each 00 00 01 opens a payload; when the next start code's 01 byte or the
// last byte closes a non-empty payload, one descriptor beat leaves on
// out_chan (offset, trimmed length, AVC/HEVC types, TRAIL_R->TRAIL_N flag,
// running patch count). The last byte always gives a beat with
// end_of_buffer set, bare if no payload closes there, and clears all state.
// Throughput: one byte per cycle while in_chan.ready stays high; the scanner
// state updates in the same cycle the byte is taken.
// A descriptor is built combinationally from the accepted byte and lands in
// the output register, or in the skid stage while that register is held.
// Stall: the output register has a one-entry skid stage behind it, so bytes
// keep flowing while one descriptor waits; in_chan.ready drops only once
// both are full, and rises again the cycle after out_chan takes a beat.
// Reset (rst_n low, synchronous) empties the output and returns the scanner
// to its start state, with no start code seen. No clearing pass.
// Depends on anx_pkg, anx_if, anx_scan and anx_skid.
`default_nettype none

module annexb_nal_splitter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  anx_in_if.sink     in_chan,
  anx_out_if.source  out_chan
);
  import anx_pkg::*;

  logic  fire;
  logic  desc_valid;
  desc_t desc;
  desc_t out_desc;

  assign fire = in_chan.valid && in_chan.ready;

  anx_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_fire  (fire),
    .beat_byte  (in_chan.byte_in),
    .beat_last  (in_chan.last_byte),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  anx_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (desc_valid),
    .up_data    (desc),
    .up_ready   (in_chan.ready),
    .down_valid (out_chan.valid),
    .down_data  (out_desc),
    .down_ready (out_chan.ready)
  );

  // Unpack the descriptor onto the channel
  assign out_chan.nal_valid          = out_desc.nal_valid;
  assign out_chan.nal_offset         = out_desc.nal_offset;
  assign out_chan.nal_length         = out_desc.nal_length;
  assign out_chan.avc_type           = out_desc.avc_type;
  assign out_chan.hevc_type          = out_desc.hevc_type;
  assign out_chan.rewrite_to_trail_n = out_desc.rewrite_to_trail_n;
  assign out_chan.patch_count        = out_desc.patch_count;
  assign out_chan.end_of_buffer      = out_desc.end_of_buffer;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for annexb_nal_splitter: byte beats in, descriptors checked
// against an in-bench scanner model. Needs anx_pkg, anx_if and the splitter RTL.
`timescale 1ns / 1ps

module testbench;
  import anx_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  anx_in_if  in_bus ();
  anx_out_if out_bus ();

  annexb_nal_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner model state, block widths (scan_start is one bit wider)
  logic [POS_W-1:0]   scan_pos;
  logic               scan_open;
  logic [ZRUN_W-1:0]  scan_zrun;
  logic [POS_W-1:0]   scan_start;
  logic [POS_W-1:0]   scan_nz_end;
  logic [BYTE_W-1:0]  scan_head [2];
  logic [ZRUN_W-1:0]  scan_head_cnt;
  logic [PATCH_W-1:0] scan_patches;

  desc_t              expected_desc [$];
  logic [BYTE_W-1:0]  stream_q [$];

  int  err_count;
  int  bytes_sent;
  int  buffers_sent;
  int  nals_seen;
  int  flagged_seen;
  int  markers_seen;
  int  long_holds;
  int  rx_hold = 0;
  bit  tx_quiet;
  bit  rx_quiet;

  function automatic void clear_scan();
    scan_pos      = '0;
    scan_open     = 1'b0;
    scan_zrun     = '0;
    scan_start    = '0;
    scan_nz_end   = '0;
    scan_head[0]  = BYTE_ZERO;
    scan_head[1]  = BYTE_ZERO;
    scan_head_cnt = '0;
    scan_patches  = '0;
  endfunction

  // Close the open payload; bare marker only when eob and nothing to describe
  function automatic bit close_payload(input bit eob, output desc_t d);
    logic [POS_W-1:0] len;
    bit               flag;
    d   = '0;
    len = (scan_open && scan_nz_end > scan_start) ? scan_nz_end - scan_start : '0;
    if (len == '0) begin
      if (!eob) return 1'b0;
      d.patch_count   = scan_patches;
      d.end_of_buffer = 1'b1;
      return 1'b1;
    end
    flag = (len > 1) && (scan_head[0] == HEVC_TRAIL_R) &&
           ((scan_head[1] & LAYER_MASK) == BYTE_ZERO);
    if (flag && scan_patches < PATCH_LIMIT) scan_patches++;
    d.nal_valid          = 1'b1;
    d.nal_offset         = scan_start[OFFSET_W-1:0];
    d.nal_length         = len;
    d.avc_type           = scan_head[0][4:0];
    d.hevc_type          = scan_head[0][6:1];
    d.rewrite_to_trail_n = flag;
    d.patch_count        = scan_patches;
    d.end_of_buffer      = eob;
    return 1'b1;
  endfunction

  // Advance the scanner by one byte; returns 1 when a descriptor is due
  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic lb,
                                   output desc_t d);
    logic [POS_W-1:0] idx;
    bit               got;
    got = 1'b0;
    d   = '0;
    idx = (scan_pos < POS_MAX) ? scan_pos : POS_W'(IDX_LAST);
    if (b == BYTE_ONE && scan_zrun >= RUN_SAT) begin
      got           = close_payload(lb, d);
      scan_open     = 1'b1;
      scan_start    = (idx + 1 < POS_MAX) ? POS_W'(idx + 1) : POS_W'(IDX_LAST);
      scan_nz_end   = scan_start;
      scan_head[0]  = BYTE_ZERO;
      scan_head[1]  = BYTE_ZERO;
      scan_head_cnt = '0;
      scan_zrun     = '0;
    end else begin
      if (b == BYTE_ZERO) begin
        if (scan_zrun < RUN_SAT) scan_zrun++;
      end else begin
        scan_zrun = '0;
      end
      if (scan_open) begin
        if (scan_head_cnt < RUN_SAT) begin
          scan_head[scan_head_cnt[0]] = b;
          scan_head_cnt++;
        end
        if (b != BYTE_ZERO) scan_nz_end = POS_W'(idx + 1);
      end
      if (lb) got = close_payload(1'b1, d);
    end
    if (scan_pos < POS_MAX) scan_pos++;
    if (lb) clear_scan();
    return got;
  endfunction

  // Send up to count bytes from the front of stream_q; last_byte on its final byte
  task automatic send_stream(input int count);
    int                gap;
    logic [BYTE_W-1:0] b;
    logic              lb;
    desc_t             d;
    repeat (count) begin
      if (stream_q.size() == 0) break;
      b   = stream_q.pop_front();
      lb  = (stream_q.size() == 0);
      gap = tx_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_bus.valid     <= 1'b1;
      in_bus.byte_in   <= b;
      in_bus.last_byte <= lb;
      do @(posedge clk); while (!in_bus.ready);
      bytes_sent++;
      if (lb) buffers_sent++;
      if (scan_byte(b, lb, d)) expected_desc.push_back(d);
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_desc.size() != 0);
  endtask

  task automatic push_start_code(input bit four);
    if (four) stream_q.push_back(BYTE_ZERO);
    stream_q.push_back(BYTE_ZERO);
    stream_q.push_back(BYTE_ZERO);
    stream_q.push_back(BYTE_ONE);
  endtask

  // Well-formed buffer: optional junk, a few NALs with random content
  task automatic gen_well_formed();
    logic [BYTE_W-1:0] hdr;
    stream_q.delete();
    repeat ($urandom_range(0, 3)) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 5)) begin
      push_start_code($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) != 0) begin
        hdr = ($urandom_range(0, 2) == 0) ? HEVC_TRAIL_R : BYTE_W'($urandom_range(0, 255));
        stream_q.push_back(hdr);
        if ($urandom_range(0, 1) == 1)
          stream_q.push_back(BYTE_W'($urandom_range(0, 7)));
        repeat ($urandom_range(0, 8))
          stream_q.push_back(($urandom_range(0, 2) == 0) ? BYTE_ZERO
                                                        : BYTE_W'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 2)) stream_q.push_back(BYTE_ZERO);
      end
    end
    // sometimes finish on a bare start code
    if ($urandom_range(0, 5) == 0) push_start_code(1'b0);
  endtask

  // Noise: zero/one heavy junk, broken and over-long start codes
  task automatic gen_noise();
    stream_q.delete();
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 3))
        0:       stream_q.push_back(BYTE_ZERO);
        1:       stream_q.push_back(BYTE_ONE);
        2: begin
          stream_q.push_back(BYTE_ZERO);
          stream_q.push_back(BYTE_ONE);
        end
        default: stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Hand-built buffers: junk before first start code, four-byte start code,
  // flagged TRAIL_R, layer bits set, last byte on a delimiter, single-byte
  // buffer, empty payloads and a bare marker carrying a non-zero patch count
  task automatic test_directed_cases();
    stream_q = '{8'hFF, BYTE_ZERO, BYTE_ZERO, BYTE_ONE, HEVC_TRAIL_R, BYTE_ONE, 8'hAA,
                 BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE, 8'h26, BYTE_ZERO};
    send_stream(stream_q.size());
    stream_q = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, HEVC_TRAIL_R, 8'h08,
                 BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
    send_stream(stream_q.size());
    stream_q = '{8'h7F};
    send_stream(1);
    stream_q = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, HEVC_TRAIL_R, BYTE_ZERO, 8'h05,
                 BYTE_ZERO, BYTE_ZERO, BYTE_ONE, BYTE_ZERO};
    send_stream(stream_q.size());
  endtask

  task automatic test_random_buffers(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 5) == 0) gen_noise();
      else gen_well_formed();
      tx_quiet = ($urandom_range(0, 3) == 0);
      send_stream(stream_q.size());
    end
  endtask

  // Long receiver hold while short NALs pour in back to back
  task automatic test_output_stall();
    stream_q.delete();
    repeat (12) begin
      push_start_code(1'b0);
      stream_q.push_back(HEVC_TRAIL_R);
      stream_q.push_back(BYTE_W'($urandom_range(0, 15)));
    end
    tx_quiet = 1'b1;
    rx_hold  = 150;
    send_stream(stream_q.size());
    tx_quiet = 1'b0;
  endtask

  // Sender stops mid-buffer until every descriptor has drained
  task automatic test_drain_pause();
    gen_well_formed();
    send_stream(stream_q.size() / 2);
    wait_drained();
    send_stream(stream_q.size());
  endtask

  // Receiver: random stalls, quiet stretches, one long hold on request
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        long_holds++;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Descriptor checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    desc_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_desc.size() == 0) begin
        $display("%0t: unexpected descriptor beat, expected none, got offset %0h len %0h",
                 $time, out_bus.nal_offset, out_bus.nal_length);
        err_count++;
      end else begin
        want = expected_desc.pop_front();
        check_field("nal_valid", 32'(want.nal_valid), 32'(out_bus.nal_valid));
        check_field("nal_offset", 32'(want.nal_offset), 32'(out_bus.nal_offset));
        check_field("nal_length", 32'(want.nal_length), 32'(out_bus.nal_length));
        check_field("avc_type", 32'(want.avc_type), 32'(out_bus.avc_type));
        check_field("hevc_type", 32'(want.hevc_type), 32'(out_bus.hevc_type));
        check_field("rewrite_to_trail_n", 32'(want.rewrite_to_trail_n),
                    32'(out_bus.rewrite_to_trail_n));
        check_field("patch_count", 32'(want.patch_count), 32'(out_bus.patch_count));
        check_field("end_of_buffer", 32'(want.end_of_buffer),
                    32'(out_bus.end_of_buffer));
      end
      if (out_bus.nal_valid) nals_seen++;
      if (out_bus.rewrite_to_trail_n) flagged_seen++;
      if (out_bus.end_of_buffer) markers_seen++;
    end
  end

  // Main sequence
  initial begin
    int waited;
    clear_scan();
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.byte_in   <= '0;
    in_bus.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_buffers(520);
    test_output_stall();
    test_drain_pause();
    test_random_buffers(40);

    // let the tail drain, bounded
    in_bus.valid <= 1'b0;
    waited = 0;
    while (expected_desc.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_desc.size() != 0) begin
      $display("%0t: %0d descriptors expected, got none", $time, expected_desc.size());
      err_count++;
    end

    $display("covered %0d bytes in %0d buffers: %0d NAL descriptors, %0d TRAIL_N flags,",
             bytes_sent, buffers_sent, nals_seen, flagged_seen);
    $display("  %0d end-of-buffer beats, %0d long output holds, %0d errors",
             markers_seen, long_holds, err_count);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
